// ===== src/sweep_packet_collector_defines.svh =====
// Assertion macros for the sweep packet collector.
// Used by the port checker; expects clk_i and rst_ni in the using scope.
`ifndef SWEEP_PACKET_COLLECTOR_DEFINES_SVH
`define SWEEP_PACKET_COLLECTOR_DEFINES_SVH

// Clocked check, idle while reset is asserted
`define SPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define SPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/spc_pkg.sv =====
// Shared types and constants for the sweep packet collector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spc_pkg;

  // Limits of the packet and word counts
  localparam int unsigned MAX_PACKETS = 16;
  localparam int unsigned MAX_WORDS   = 1024;

  // Header word layout
  localparam logic [7:0] EXP_BIAS   = 8'd243;
  localparam int unsigned NUM_SHIFT = 4;
  localparam int unsigned PRE_SHIFT = 5;

  // Widths
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned VALUE_W  = WORD_W + PRE_SHIFT;
  localparam int unsigned INDEX_W  = 14;
  localparam int unsigned PKT_W    = 4;
  localparam int unsigned PCNT_W   = 5;
  localparam int unsigned WIP_W    = 10;
  localparam int unsigned WCNT_W   = 11;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKETS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS       = 2'd3;

  // Sweep phases
  localparam logic PHASE_RISE = 1'b0;
  localparam logic PHASE_FALL = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              first_word;
    logic              receive_fail;
  } in_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic               sweep_select;
    logic [INDEX_W-1:0] sample_index;
    logic               collection_done;
    logic               failed;
  } out_res_t;

  // Settings as the datapath sees them, counts already clamped
  typedef struct packed {
    logic [CODE_W-1:0] rise_code;
    logic [CODE_W-1:0] fall_code;
    logic [PCNT_W-1:0] packets;
    logic [WCNT_W-1:0] words;
  } cfg_t;

endpackage

// ===== src/spc_cfg.sv =====
// Configuration registers of the sweep packet collector.
// Holds the four settings and clamps the counts; uses spc_pkg.
`timescale 1ns / 1ps

module spc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output spc_pkg::cfg_t                  cfg_o
);

  logic [spc_pkg::CODE_W-1:0] rise_q, fall_q;
  logic [spc_pkg::PCNT_W-1:0] pkts_q;
  logic [spc_pkg::WCNT_W-1:0] words_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q  <= spc_pkg::CODE_W'(0);
      fall_q  <= spc_pkg::CODE_W'(1);
      pkts_q  <= spc_pkg::PCNT_W'(4);
      words_q <= spc_pkg::WCNT_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spc_pkg::CFG_RISE_CODE: rise_q  <= cfg_wdata_i[spc_pkg::CODE_W-1:0];
        spc_pkg::CFG_FALL_CODE: fall_q  <= cfg_wdata_i[spc_pkg::CODE_W-1:0];
        spc_pkg::CFG_PACKETS:   pkts_q  <= cfg_wdata_i[spc_pkg::PCNT_W-1:0];
        spc_pkg::CFG_WORDS:     words_q <= cfg_wdata_i[spc_pkg::WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts into their legal range
  always_comb begin
    cfg_o.rise_code = rise_q;
    cfg_o.fall_code = fall_q;
    if (pkts_q == '0) begin
      cfg_o.packets = spc_pkg::PCNT_W'(1);
    end else if (pkts_q > spc_pkg::PCNT_W'(spc_pkg::MAX_PACKETS)) begin
      cfg_o.packets = spc_pkg::PCNT_W'(spc_pkg::MAX_PACKETS);
    end else begin
      cfg_o.packets = pkts_q;
    end
    if (words_q == '0) begin
      cfg_o.words = spc_pkg::WCNT_W'(1);
    end else if (words_q > spc_pkg::WCNT_W'(spc_pkg::MAX_WORDS)) begin
      cfg_o.words = spc_pkg::WCNT_W'(spc_pkg::MAX_WORDS);
    end else begin
      cfg_o.words = words_q;
    end
  end

endmodule

// ===== src/sweep_packet_collector.sv =====
// Sweep packet collector: packet sequencing, sample scaling and result register.
// Uses spc_pkg and spc_cfg.
`timescale 1ns / 1ps

// Takes one packet word per cycle and gives at most one sample per word, in the
// cycle after the word is accepted. Throughput is one word per cycle while the
// result side takes results; the single result register sets that figure, and
// a word is accepted while a finished result is being taken in the same cycle.
// Header words and words of skipped packets give no result. A receive failure
// gives one result with failed set and restarts collection at the rise sweep.
// Settings may be written only while the block is idle.
module sweep_packet_collector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  spc_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output spc_pkg::out_res_t              out_res_o
);

  spc_pkg::cfg_t cfg;

  logic                         phase_q, phase_d;
  logic [spc_pkg::PKT_W-1:0]    exp_pkt_q, exp_pkt_d;
  logic [spc_pkg::WIP_W-1:0]    wip_q, wip_d;
  logic                         acc_q, acc_d;
  logic [spc_pkg::SHIFT_W-1:0]  shift_q, shift_d;
  logic [spc_pkg::INDEX_W-1:0]  offs_q, offs_d;

  logic                         out_valid_q, out_valid_d;
  spc_pkg::out_res_t            out_res_q, out_res_d;

  logic                         accept;
  logic                         res_valid;
  logic [spc_pkg::CODE_W-1:0]   hdr_dir, want_dir;
  logic [spc_pkg::PKT_W-1:0]    hdr_num;
  logic [7:0]                   hdr_hi, hdr_exp;
  logic [spc_pkg::WCNT_W-1:0]   wip_inc;
  logic [spc_pkg::PCNT_W-1:0]   pkt_inc;
  logic [spc_pkg::VALUE_W-1:0]  scaled;

  spc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Take a request when the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode header fields
  assign hdr_dir  = in_req_i.data_word[spc_pkg::CODE_W-1:0];
  assign hdr_num  = in_req_i.data_word[spc_pkg::NUM_SHIFT +: spc_pkg::PKT_W];
  assign hdr_hi   = in_req_i.data_word[15:8];
  assign hdr_exp  = hdr_hi - spc_pkg::EXP_BIAS;
  assign want_dir = (phase_q == spc_pkg::PHASE_FALL) ? cfg.fall_code : cfg.rise_code;

  // Scale the sample and advance the counters
  assign scaled  = {in_req_i.data_word, spc_pkg::PRE_SHIFT'(0)} >> shift_q;
  assign wip_inc = spc_pkg::WCNT_W'(wip_q) + spc_pkg::WCNT_W'(1);
  assign pkt_inc = spc_pkg::PCNT_W'(exp_pkt_q) + spc_pkg::PCNT_W'(1);

  // Next collection state and result
  always_comb begin
    phase_d   = phase_q;
    exp_pkt_d = exp_pkt_q;
    wip_d     = wip_q;
    acc_d     = acc_q;
    shift_d   = shift_q;
    offs_d    = offs_q;
    res_valid = 1'b0;

    out_res_d.sample_value    = scaled;
    out_res_d.sweep_select    = phase_q;
    out_res_d.sample_index    = offs_q + spc_pkg::INDEX_W'(wip_q);
    out_res_d.collection_done = 1'b0;
    out_res_d.failed          = 1'b0;

    if (in_req_i.receive_fail) begin
      // Abort: restart and report the failure
      phase_d   = spc_pkg::PHASE_RISE;
      exp_pkt_d = '0;
      wip_d     = '0;
      acc_d     = 1'b0;
      shift_d   = '0;
      offs_d    = '0;
      res_valid = 1'b1;
      out_res_d = '0;
      out_res_d.failed = 1'b1;
    end else if (in_req_i.first_word) begin
      // Open the packet if it is the one expected, otherwise skip it
      wip_d = '0;
      if (hdr_num == exp_pkt_q && hdr_dir == want_dir) begin
        acc_d   = 1'b1;
        shift_d = (hdr_hi < spc_pkg::EXP_BIAS) ? '0 : hdr_exp[spc_pkg::SHIFT_W-1:0];
      end else begin
        acc_d = 1'b0;
      end
    end else if (acc_q) begin
      res_valid = 1'b1;
      wip_d     = wip_inc[spc_pkg::WIP_W-1:0];
      if (wip_inc >= cfg.words) begin
        // Close the packet
        acc_d  = 1'b0;
        wip_d  = '0;
        offs_d = offs_q + spc_pkg::INDEX_W'(cfg.words);
        if (pkt_inc >= cfg.packets) begin
          if (phase_q == spc_pkg::PHASE_RISE) begin
            phase_d   = spc_pkg::PHASE_FALL;
            exp_pkt_d = '0;
            offs_d    = '0;
          end else begin
            out_res_d.collection_done = 1'b1;
            phase_d   = spc_pkg::PHASE_RISE;
            exp_pkt_d = '0;
            shift_d   = '0;
            offs_d    = '0;
          end
        end else begin
          exp_pkt_d = pkt_inc[spc_pkg::PKT_W-1:0];
        end
      end
    end
  end

  // Hold or load the result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Collection state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= spc_pkg::PHASE_RISE;
      exp_pkt_q   <= '0;
      wip_q       <= '0;
      acc_q       <= 1'b0;
      shift_q     <= '0;
      offs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q   <= phase_d;
        exp_pkt_q <= exp_pkt_d;
        wip_q     <= wip_d;
        acc_q     <= acc_d;
        shift_q   <= shift_d;
        offs_q    <= offs_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== src/spc_checker.sv =====
// Port checker for the sweep packet collector, bound to the top level.
// Uses spc_pkg and the macros of sweep_packet_collector_defines.svh.
`timescale 1ns / 1ps
`include "sweep_packet_collector_defines.svh"

module spc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input spc_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input spc_pkg::out_res_t out_res_o
);

  // A failure request gives a failure result next cycle
  `SPC_ASSERT(a_fail_result, in_valid_i && in_ready_o && in_req_i.receive_fail |=> out_valid_o && out_res_o.failed, "failure request gave no failure result")

  // A header gives no result
  `SPC_ASSERT(a_hdr_silent, in_valid_i && in_ready_o && in_req_i.first_word && !in_req_i.receive_fail |=> !out_valid_o, "header word gave a result")

  // A failure result carries no sample
  `SPC_ASSERT(a_fail_clean, out_valid_o && out_res_o.failed |-> out_res_o.sample_value == '0 && out_res_o.sample_index == '0 && !out_res_o.sweep_select && !out_res_o.collection_done, "failure result carries sample fields")

  // Hold a waiting result unchanged until it is taken
  `SPC_ASSERT(a_hold_result, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o), "waiting result dropped or changed")

  // No result in the cycle after reset is seen
  `SPC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind sweep_packet_collector spc_checker u_spc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);
